// ----- hdl/ssu_pkg.sv -----
// ----------------------------------------------------------------------------
// ssu_pkg
// Shared types, sizes and the decay table for the selective scan state update.
// ----------------------------------------------------------------------------
package ssu_pkg;

  localparam int LAYERS      = 4;
  localparam int CHANNELS    = 256;
  localparam int STATES      = 16;
  localparam int LAY_W       = $clog2(LAYERS);
  localparam int CH_W        = $clog2(CHANNELS);
  localparam int ST_W        = $clog2(STATES);
  localparam int ADDR_W      = LAY_W + CH_W + ST_W;
  localparam int STORE_DEPTH = LAYERS * CHANNELS * STATES;

  localparam int EXP_SIZE = 1024;
  localparam int EXP_AW   = $clog2(EXP_SIZE);
  localparam int EXP_W    = 17;
  localparam logic [63:0] EXP_RATIO = 64'd1065385899;

  localparam int MUL_AW = 32;
  localparam int MUL_BW = 18;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  typedef struct packed {
    logic        [1:0]  layer;
    logic        [7:0]  channel;
    logic        [3:0]  state_index;
    logic        [14:0] step_size;
    logic signed [15:0] a_coef;
    logic signed [15:0] b_val;
    logic signed [15:0] c_val;
    logic signed [15:0] u_val;
    logic signed [15:0] skip_d;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] y_out;
    logic        [1:0]  out_layer;
    logic        [7:0]  out_channel;
  } out_item_t;

  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [31:0]       wdata;
    logic                     re;
    logic [ADDR_W-1:0]        raddr;
  } mem_req_t;

  typedef logic [EXP_W-1:0] exp_tab_t [EXP_SIZE];

  // exp(-k/128) in Q1.16, geometric recurrence in Q2.30
  function automatic exp_tab_t build_exp();
    exp_tab_t    t;
    logic [63:0] e;
    e = 64'd1 << 30;
    for (int k = 0; k < EXP_SIZE; k++) begin
      t[k] = EXP_W'((e + 64'd8192) >> 14);
      e = (e * EXP_RATIO + (64'd1 << 29)) >> 30;
    end
    return t;
  endfunction

endpackage

// ----- hdl/selective_scan_state_update.sv -----
// ----------------------------------------------------------------------------
// selective_scan_state_update
// One scan element per transfer: state decay and drive, channel sum, output.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  input   | in_valid, in_stall, in_data    | in_item_t
//  result  | out_valid, out_stall, out_data | out_item_t (only when last)
//
// Each element runs six products in turn on the one shared multiplier plus
// state read, update and write-back. After reset a clearing pass zeroes all
// 16384 entries of the state store, with in_stall high. A result waits in
// the output register; the next element is taken meanwhile and only its own
// result stalls until the register frees.
// ----------------------------------------------------------------------------
module selective_scan_state_update
  import ssu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_DB,
    ST_MUL_BU,
    ST_MUL_HQ,
    ST_UPD,
    ST_MUL_HC,
    ST_MUL_UD,
    ST_FIN
  } state_t;

  state_t             state_r, state_nxt;
  logic               clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  in_item_t           item_r, item_nxt;
  logic signed [25:0] drv_r, drv_nxt;
  logic signed [31:0] hn_r, hn_nxt;
  logic signed [47:0] sum_r, sum_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  mem_req_t                 mem_req;
  logic signed [31:0]       h_old;
  logic                     rom_en;
  logic [EXP_AW-1:0]        rom_addr;
  logic [EXP_W-1:0]         q_val;
  logic                     mul_en;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] prod;
  logic                     accept;
  logic [ADDR_W-1:0]        item_addr;

  ssu_state_mem u_mem (
    .clk  (clk),
    .req  (mem_req),
    .rd_q (h_old)
  );

  ssu_exp_rom u_rom (
    .clk     (clk),
    .rd_en   (rom_en),
    .rd_addr (rom_addr),
    .rd_q    (q_val)
  );

  ssu_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  assign in_stall  = clr_busy_r || (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign item_addr = {item_r.layer[LAY_W-1:0], item_r.channel[CH_W-1:0],
                      item_r.state_index[ST_W-1:0]};

  // memory port
  always_comb begin
    mem_req.re    = accept;
    mem_req.raddr = {in_data.layer[LAY_W-1:0], in_data.channel[CH_W-1:0],
                     in_data.state_index[ST_W-1:0]};
    if (clr_busy_r) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = clr_addr_r;
      mem_req.wdata = '0;
    end else begin
      mem_req.we    = (state_r == ST_MUL_HC);
      mem_req.waddr = item_addr;
      mem_req.wdata = hn_r;
    end
  end

  // decay index: round(-x / 2^17), clamped; x >= 0 gives entry 0 = 1.0
  always_comb begin
    logic signed [31:0] x;
    logic [31:0]        nx;
    logic [31:0]        kf;
    x  = prod[31:0];
    nx = 32'(-x);
    kf = (nx + 32'd65536) >> 17;
    rom_en = (state_r == ST_MUL_DB);
    if (!x[31]) begin
      rom_addr = '0;
    end else if (kf > 32'(EXP_SIZE - 1)) begin
      rom_addr = EXP_AW'(EXP_SIZE - 1);
    end else begin
      rom_addr = kf[EXP_AW-1:0];
    end
  end

  // multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      ST_MUL_X: begin
        mul_a = MUL_AW'({1'b0, item_r.step_size});
        mul_b = MUL_BW'(item_r.a_coef);
      end
      ST_MUL_DB: begin
        mul_a = MUL_AW'({1'b0, item_r.step_size});
        mul_b = MUL_BW'(item_r.b_val);
      end
      ST_MUL_BU: begin
        mul_a = prod[MUL_AW-1:0];
        mul_b = MUL_BW'(item_r.u_val);
      end
      ST_MUL_HQ: begin
        mul_a = h_old;
        mul_b = MUL_BW'({1'b0, q_val});
      end
      ST_MUL_HC: begin
        mul_a = hn_r;
        mul_b = MUL_BW'(item_r.c_val);
      end
      ST_MUL_UD: begin
        mul_a = MUL_AW'(item_r.u_val);
        mul_b = MUL_BW'(item_r.skip_d);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    logic signed [MUL_PW-1:0] rnd_t;
    logic signed [34:0]       hs;
    logic signed [47:0]       base;
    logic signed [48:0]       acc;
    logic signed [MUL_PW-1:0] yt;
    logic signed [37:0]       ys;

    state_nxt     = state_r;
    clr_busy_nxt  = clr_busy_r;
    clr_addr_nxt  = clr_addr_r;
    item_nxt      = item_r;
    drv_nxt       = drv_r;
    hn_nxt        = hn_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    rnd_t = '0;
    hs    = '0;
    base  = '0;
    acc   = '0;
    yt    = '0;
    ys    = '0;

    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        clr_busy_nxt = 1'b0;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_nxt  = in_data;
          state_nxt = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        state_nxt = ST_MUL_DB;
      end
      ST_MUL_DB: begin
        state_nxt = ST_MUL_BU;
      end
      ST_MUL_BU: begin
        state_nxt = ST_MUL_HQ;
      end
      ST_MUL_HQ: begin
        rnd_t     = (prod + (MUL_PW'(1) <<< 23)) >>> 24;
        drv_nxt   = rnd_t[25:0];
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        rnd_t = (prod + (MUL_PW'(1) <<< 15)) >>> 16;
        hs    = 35'($signed(rnd_t[33:0])) + 35'(drv_r);
        if (hs > 35'sh07FFFFFFF) begin
          hn_nxt = 32'sh7FFFFFFF;
        end else if (hs < -35'sh080000000) begin
          hn_nxt = 32'sh80000000;
        end else begin
          hn_nxt = hs[31:0];
        end
        state_nxt = ST_MUL_HC;
      end
      ST_MUL_HC: begin
        state_nxt = ST_MUL_UD;
      end
      ST_MUL_UD: begin
        base = (item_r.state_index[ST_W-1:0] == '0) ? '0 : sum_r;
        acc  = 49'(base) + 49'($signed(prod[47:0]));
        if (acc[48] != acc[47]) begin
          sum_nxt = acc[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
          sum_nxt = acc[47:0];
        end
        state_nxt = item_r.last ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          yt = MUL_PW'(sum_r) + prod + (MUL_PW'(1) <<< 11);
          ys = 38'(yt >>> 12);
          if (ys > 38'sh007FFFFFFF) begin
            out_data_nxt.y_out = 32'sh7FFFFFFF;
          end else if (ys < -38'sh0080000000) begin
            out_data_nxt.y_out = 32'sh80000000;
          end else begin
            out_data_nxt.y_out = ys[31:0];
          end
          out_data_nxt.out_layer   = 2'(item_r.layer[LAY_W-1:0]);
          out_data_nxt.out_channel = 8'(item_r.channel[CH_W-1:0]);
          out_valid_nxt = 1'b1;
          sum_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    drv_r      <= drv_nxt;
    hn_r       <= hn_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- hdl/ssu_exp_rom.sv -----
// ----------------------------------------------------------------------------
// ssu_exp_rom
// Decay factor lookup, 1024 entries of Q1.16, registered read.
// ----------------------------------------------------------------------------
module ssu_exp_rom
  import ssu_pkg::*;
(
  input  logic              clk,
  input  logic              rd_en,
  input  logic [EXP_AW-1:0] rd_addr,
  output logic [EXP_W-1:0]  rd_q
);

  localparam exp_tab_t EXP_ROM = build_exp();

  logic [EXP_W-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= EXP_ROM[rd_addr];
    end
  end

  assign rd_q = rd_q_r;

endmodule

// ----- hdl/ssu_state_mem.sv -----
// ----------------------------------------------------------------------------
// ssu_state_mem
// Scan state store, one write and one registered read port.
// ----------------------------------------------------------------------------
module ssu_state_mem
  import ssu_pkg::*;
(
  input  logic               clk,
  input  mem_req_t           req,
  output logic signed [31:0] rd_q
);

  logic signed [31:0] mem [STORE_DEPTH];
  logic signed [31:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_q_r <= mem[req.raddr];
    end
  end

  assign rd_q = rd_q_r;

endmodule

// ----- hdl/ssu_mul.sv -----
// ----------------------------------------------------------------------------
// ssu_mul
// Shared signed multiplier, 32 x 18, with product register.
// ----------------------------------------------------------------------------
module ssu_mul
  import ssu_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [MUL_AW-1:0] op_a,
  input  logic signed [MUL_BW-1:0] op_b,
  output logic signed [MUL_PW-1:0] prod
);

  logic signed [MUL_PW-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= MUL_PW'(op_a) * MUL_PW'(op_b);
    end
  end

  assign prod = prod_r;

endmodule

// ----- hdl/ssu_checker.sv -----
// ----------------------------------------------------------------------------
// ssu_checker
// Port-level checks for the selective scan state update.
// ----------------------------------------------------------------------------
module ssu_checker
  import ssu_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // clearing pass blocks input right after reset
  a_clr_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open during clearing pass");

  // one element at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer taken while busy");

  // a new result follows busy cycles
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall, 1) && $past(in_stall, 2))
    else $error("result without element in progress");

endmodule

bind selective_scan_state_update ssu_checker u_ssu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
